>>> hw/rtl/stpt_pkg.sv
// Shared types and constants for the segmented TLB and page-table unit.
// Used by stpt_cell, stpt_chain and segmented_tlb_page_table_model_unit.
package stpt_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 32;
   localparam int SEG_W = 2;
   localparam int PCNT_W = 11;
   localparam int COST_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [1:0] SEG_INVALID = 2'd3;

   typedef enum logic [1:0] {
      OUT_INVALID = 2'd0,
      OUT_TLB_HIT = 2'd1,
      OUT_TAB_HIT = 2'd2,
      OUT_FAULT   = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      CSR_SEG0_PAGES = 3'd0,
      CSR_SEG1_PAGES = 3'd1,
      CSR_SEG2_PAGES = 3'd2,
      CSR_HIT_COST   = 3'd3,
      CSR_MISS_COST  = 3'd4,
      CSR_FAULT_COST = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Search token that travels down a row of cells, one cell a cycle.
   typedef struct packed {
      logic             active;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             empty;
      logic [IDX_W-1:0] best_idx;
      logic [CNT_W-1:0] best_cnt;
   } carry_type;

   // Update broadcast to every cell of a row.
   typedef struct packed {
      logic             wr;
      logic             bump;
      logic             inc_all;
      logic [IDX_W-1:0] idx;
   } cmd_type;

endpackage

>>> hw/rtl/segmented_tlb_page_table_model_unit.sv
// Segmented translation unit: a FIFO-replaced TLB and a page table whose
// victim is the entry with the fewest uses, each held in a row of cells.
// A search token ripples through each row one cell per cycle. One request is
// handled at a time: a new request is taken only after the last result has
// been committed, and a commit waits until the result register is free.
// Reset (synchronous, active high) empties the TLB, preloads table entries 0..2
// and restores the register defaults.
module segmented_tlb_page_table_model_unit #(
   parameter int TLB_ENTRIES = 64,
   parameter int TABLE_ENTRIES = 128,
   parameter int PAGE_BITS = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] segment, [PAGE_BITS+1:2] page, rest zero
   input  logic [((2+PAGE_BITS+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] outcome, [7:2] tlb_slot, [14:8] table_slot, [46:15] access_count,
   // [78:47] tlb_miss_count, [110:79] fault_count, [142:111] invalid_count,
   // [174:143] total_delay, [175] zero
   output logic [175:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import stpt_pkg::*;

   localparam int CMP_W = (PAGE_BITS > PCNT_W) ? PAGE_BITS : PCNT_W;

   // Configuration registers.
   logic [PCNT_W-1:0] pages_ff [3];
   logic [COST_W-1:0] hit_cost_ff, miss_cost_ff, fault_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff[0] <= '0;
         pages_ff[1] <= '0;
         pages_ff[2] <= '0;
         hit_cost_ff <= COST_W'(1);
         miss_cost_ff <= COST_W'(10);
         fault_cost_ff <= COST_W'(100);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SEG0_PAGES: pages_ff[0] <= csr_wdata[PCNT_W-1:0];
            CSR_SEG1_PAGES: pages_ff[1] <= csr_wdata[PCNT_W-1:0];
            CSR_SEG2_PAGES: pages_ff[2] <= csr_wdata[PCNT_W-1:0];
            CSR_HIT_COST:   hit_cost_ff <= csr_wdata;
            CSR_MISS_COST:  miss_cost_ff <= csr_wdata;
            CSR_FAULT_COST: fault_cost_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [SEG_W-1:0] seg_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic ok_ff, launch_ff, launch_in;
   logic tlb_done_ff, tab_done_ff;
   carry_type tlb_res_ff, tab_res_ff, tlb_end, tab_end;
   cmd_type tlb_cmd, tab_cmd;
   logic req_fire, fire, rsp_free;
   logic [SEG_W-1:0] req_seg;
   logic [PAGE_BITS-1:0] req_page;
   logic req_ok;

   assign req_seg = req_tdata[1:0];
   assign req_page = req_tdata[PAGE_BITS+1:2];
   assign req_ok = (req_seg != SEG_INVALID) &&
                   (CMP_W'(req_page) < CMP_W'(pages_ff[req_seg]));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid || rsp_tready;

   // Sequencer: take a request, scan both rows, then commit.
   always_comb begin
      state_in = state_ff;
      launch_in = 1'b0;
      fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_fire) begin
            state_in = ST_SCAN;
            launch_in = 1'b1;
         end
         ST_SCAN: if (tlb_done_ff && tab_done_ff && rsp_free) begin
            fire = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         launch_ff <= 1'b0;
         tlb_done_ff <= 1'b0;
         tab_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= launch_in;
         if (fire) tlb_done_ff <= 1'b0;
         else if (tlb_end.active) tlb_done_ff <= 1'b1;
         if (fire) tab_done_ff <= 1'b0;
         else if (tab_end.active) tab_done_ff <= 1'b1;
      end
   end

   // Request key and captured search results.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         seg_ff <= req_seg;
         page_ff <= req_page;
         ok_ff <= req_ok;
      end
      if (tlb_end.active) tlb_res_ff <= tlb_end;
      if (tab_end.active) tab_res_ff <= tab_end;
   end

   // Commit decisions.
   logic tlb_miss, tab_hit_use, tab_fault;
   assign tlb_miss = ok_ff && !tlb_res_ff.hit;
   assign tab_hit_use = tlb_miss && tab_res_ff.hit;
   assign tab_fault = tlb_miss && !tab_res_ff.hit;

   always_comb begin
      tlb_cmd.inc_all = fire;
      tlb_cmd.wr = fire && tlb_miss;
      tlb_cmd.bump = 1'b0;
      tlb_cmd.idx = tlb_res_ff.best_idx;
      tab_cmd.inc_all = 1'b0;
      tab_cmd.wr = fire && tab_fault;
      tab_cmd.bump = fire && tab_hit_use;
      tab_cmd.idx = tab_res_ff.hit ? tab_res_ff.hit_idx : tab_res_ff.best_idx;
   end

   stpt_chain #(.N(TLB_ENTRIES), .MAXMODE(1'b1), .PRESET(0), .PW(PAGE_BITS)) u_tlb (
      .clock(clock), .reset(reset), .launch(launch_ff), .key_seg(seg_ff),
      .key_page(page_ff), .cmd(tlb_cmd), .result(tlb_end)
   );

   stpt_chain #(.N(TABLE_ENTRIES), .MAXMODE(1'b0), .PRESET(3), .PW(PAGE_BITS)) u_tab (
      .clock(clock), .reset(reset), .launch(launch_ff), .key_seg(seg_ff),
      .key_page(page_ff), .cmd(tab_cmd), .result(tab_end)
   );

   // Statistics and the result register.
   logic [CNT_W-1:0] acc_cnt_ff, miss_cnt_ff, fault_cnt_ff, inv_cnt_ff, delay_ff;
   logic [CNT_W:0] delay_sum;
   logic [COST_W-1:0] cost;
   outcome_type outcome_ff, outcome_in;
   logic [IDX_W-1:0] tslot_ff, tslot_in, pslot_ff, pslot_in;
   logic rsp_valid_ff;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   always_comb begin
      outcome_in = OUT_INVALID;
      tslot_in = '0;
      pslot_in = '0;
      cost = hit_cost_ff;
      if (ok_ff) begin
         if (tlb_res_ff.hit) begin
            outcome_in = OUT_TLB_HIT;
            tslot_in = tlb_res_ff.hit_idx;
         end else begin
            tslot_in = tlb_res_ff.best_idx;
            pslot_in = tab_cmd.idx;
            if (tab_res_ff.hit) begin
               outcome_in = OUT_TAB_HIT;
               cost = miss_cost_ff;
            end else begin
               outcome_in = OUT_FAULT;
               cost = fault_cost_ff;
            end
         end
      end
   end

   assign delay_sum = {1'b0, delay_ff} + (CNT_W+1)'(cost);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_cnt_ff <= '0;
         miss_cnt_ff <= '0;
         fault_cnt_ff <= '0;
         inv_cnt_ff <= '0;
         delay_ff <= '0;
         outcome_ff <= OUT_INVALID;
         tslot_ff <= '0;
         pslot_ff <= '0;
      end else begin
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (fire) begin
            outcome_ff <= outcome_in;
            tslot_ff <= tslot_in;
            pslot_ff <= pslot_in;
            if (ok_ff) begin
               acc_cnt_ff <= sat_inc(acc_cnt_ff);
               delay_ff <= delay_sum[CNT_W] ? CNT_MAX : delay_sum[CNT_W-1:0];
            end else begin
               inv_cnt_ff <= sat_inc(inv_cnt_ff);
            end
            if (tlb_miss) miss_cnt_ff <= sat_inc(miss_cnt_ff);
            if (tab_fault) fault_cnt_ff <= sat_inc(fault_cnt_ff);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, delay_ff, inv_cnt_ff, fault_cnt_ff, miss_cnt_ff, acc_cnt_ff,
                       pslot_ff[6:0], tslot_ff[5:0], outcome_ff};

   // Checks on the sequencer and the row updates.
   a_no_token_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tlb_end.active && !tab_end.active)
      else $error("search token seen while idle");
   a_tab_cmd: assert property (@(posedge clock) disable iff (reset)
      !(tab_cmd.wr && tab_cmd.bump))
      else $error("table write and use bump together");
   a_acc_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> acc_cnt_ff >= $past(acc_cnt_ff))
      else $error("access count went down");
   a_fire_done: assert property (@(posedge clock) disable iff (reset)
      fire |=> !tlb_done_ff && !tab_done_ff && rsp_tvalid)
      else $error("commit did not clear search state");

endmodule

>>> hw/rtl/stpt_cell.sv
// One entry of a translation row: key, valid bit and a 32-bit counter.
// Depends on stpt_pkg for the token and update structures.
module stpt_cell #(
   parameter int IDX = 0,
   parameter bit MAXMODE = 1'b1,
   parameter bit RST_VALID = 1'b0,
   parameter int RST_SEG = 0,
   parameter int PW = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [stpt_pkg::SEG_W-1:0] key_seg,
   input  logic [PW-1:0]              key_page,
   input  stpt_pkg::carry_type        carry_i,
   output stpt_pkg::carry_type        carry_o,
   input  stpt_pkg::cmd_type          cmd
);
   import stpt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic             valid_ff, valid_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic [PW-1:0]    page_ff, page_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   carry_type        carry_ff, carry_in;
   logic             match, sel;

   assign match = valid_ff && (seg_ff == key_seg) && (page_ff == key_page);
   assign sel = (cmd.idx == MY_IDX);
   assign cnt_inc = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   // Fold this entry into the passing token.
   always_comb begin
      carry_in = carry_i;
      if (carry_i.active) begin
         if (!carry_i.hit && match) begin
            carry_in.hit = 1'b1;
            carry_in.hit_idx = MY_IDX;
         end
         if (MAXMODE) begin
            if (!carry_i.empty) begin
               if (!valid_ff) begin
                  carry_in.empty = 1'b1;
                  carry_in.best_idx = MY_IDX;
               end else if (cnt_ff > carry_i.best_cnt) begin
                  carry_in.best_idx = MY_IDX;
                  carry_in.best_cnt = cnt_ff;
               end
            end
         end else if (cnt_ff < carry_i.best_cnt) begin
            carry_in.best_idx = MY_IDX;
            carry_in.best_cnt = cnt_ff;
         end
      end
   end

   // Apply the broadcast update.
   always_comb begin
      valid_in = valid_ff;
      seg_in = seg_ff;
      page_in = page_ff;
      cnt_in = cnt_ff;
      if (cmd.wr && sel) begin
         valid_in = 1'b1;
         seg_in = key_seg;
         page_in = key_page;
         cnt_in = cmd.inc_all ? CNT_W'(1) : '0;
      end else if ((cmd.bump && sel) || (cmd.inc_all && valid_ff)) begin
         cnt_in = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= RST_VALID;
         seg_ff <= SEG_W'(RST_SEG);
         page_ff <= '0;
         cnt_ff <= '0;
         carry_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         seg_ff <= seg_in;
         page_ff <= page_in;
         cnt_ff <= cnt_in;
         carry_ff <= carry_in;
      end
   end

   assign carry_o = carry_ff;

endmodule

>>> hw/rtl/stpt_chain.sv
// A row of stpt_cell instances through which a search token ripples.
// Depends on stpt_pkg and stpt_cell.
module stpt_chain #(
   parameter int N = 64,
   parameter bit MAXMODE = 1'b1,
   parameter int PRESET = 0,
   parameter int PW = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       launch,
   input  logic [stpt_pkg::SEG_W-1:0] key_seg,
   input  logic [PW-1:0]              key_page,
   input  stpt_pkg::cmd_type          cmd,
   output stpt_pkg::carry_type        result
);
   import stpt_pkg::*;

   carry_type link [N+1];

   // Token entering the first cell.
   always_comb begin
      link[0] = '0;
      link[0].active = launch;
      link[0].best_cnt = MAXMODE ? '0 : CNT_MAX;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      stpt_cell #(
         .IDX(i),
         .MAXMODE(MAXMODE),
         .RST_VALID(i < PRESET),
         .RST_SEG((i < PRESET) ? i : 0),
         .PW(PW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .key_seg(key_seg),
         .key_page(key_page),
         .carry_i(link[i]),
         .carry_o(link[i+1]),
         .cmd(cmd)
      );
   end

   assign result = link[N];

endmodule
